// ===== hw/rtl/padf_pkg.sv =====
package padf_pkg;

  // command codes carried in in_tuser
  typedef enum logic [3:0] {
    CMD_RISE  = 4'd0,
    CMD_FALL  = 4'd1,
    CMD_DEMO  = 4'd2,
    CMD_START = 4'd3,
    CMD_STOP  = 4'd4,
    CMD_ABS   = 4'd5,
    CMD_REL   = 4'd6,
    CMD_SET   = 4'd7,
    CMD_LOST  = 4'd8,
    CMD_TICK  = 4'd9
  } cmd_t;

  // fade direction codes
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // line frequency codes
  localparam logic [1:0] FREQ_UNK = 2'd0;
  localparam logic [1:0] FREQ_50  = 2'd1;
  localparam logic [1:0] FREQ_60  = 2'd2;

  // configuration register indexes
  localparam logic REG_P50 = 1'b0;
  localparam logic REG_P60 = 1'b1;

  localparam logic [15:0] P50_RST = 16'd10000;
  localparam logic [15:0] P60_RST = 16'd8333;
  localparam int          P50_TENTH = 10000 / 10;
  localparam int          P60_TENTH = 8333 / 10;
  localparam logic [15:0] LO50_RST = 16'(10000 - P50_TENTH);
  localparam logic [16:0] HI50_RST = 17'(10000 + P50_TENTH);
  localparam logic [15:0] LO60_RST = 16'(8333 - P60_TENTH);
  localparam logic [16:0] HI60_RST = 17'(8333 + P60_TENTH);

  // x/10 == (x * DIV10_MUL) >> DIV10_SHR for any 16-bit x
  localparam logic [16:0] DIV10_MUL = 17'd52429;
  localparam int          DIV10_SHR = 19;

  localparam logic [9:0]  SYNC_CAP   = 10'd600;
  localparam logic [15:0] FULL_DELAY = 16'd100;
  localparam logic [7:0]  LVL_MAX    = 8'd255;
  localparam logic [7:0]  LVL_HALF   = 8'd127;
  localparam logic [7:0]  LVL_MIRROR = 8'd254;
  localparam logic [7:0]  SPD_COARSE = 8'h80;
  localparam logic [7:0]  SPD_MASK   = 8'h7f;

  // power-linear quarter table, 845 .. 4990
  localparam logic [15:0] QUARTER_TAB [0:126] = '{
    16'd845,  16'd1068, 16'd1225, 16'd1352, 16'd1459, 16'd1553, 16'd1638, 16'd1716,
    16'd1788, 16'd1855, 16'd1917, 16'd1976, 16'd2032, 16'd2086, 16'd2138, 16'd2188,
    16'd2236, 16'd2282, 16'd2327, 16'd2370, 16'd2412, 16'd2453, 16'd2493, 16'd2532,
    16'd2570, 16'd2607, 16'd2643, 16'd2679, 16'd2714, 16'd2748, 16'd2782, 16'd2815,
    16'd2848, 16'd2880, 16'd2911, 16'd2942, 16'd2972, 16'd3002, 16'd3032, 16'd3061,
    16'd3090, 16'd3119, 16'd3147, 16'd3175, 16'd3203, 16'd3230, 16'd3257, 16'd3284,
    16'd3311, 16'd3337, 16'd3363, 16'd3389, 16'd3415, 16'd3440, 16'd3465, 16'd3490,
    16'd3515, 16'd3539, 16'd3563, 16'd3587, 16'd3611, 16'd3635, 16'd3659, 16'd3682,
    16'd3705, 16'd3728, 16'd3751, 16'd3774, 16'd3797, 16'd3820, 16'd3843, 16'd3865,
    16'd3887, 16'd3909, 16'd3931, 16'd3953, 16'd3975, 16'd3997, 16'd4019, 16'd4041,
    16'd4062, 16'd4083, 16'd4104, 16'd4125, 16'd4146, 16'd4167, 16'd4188, 16'd4209,
    16'd4230, 16'd4251, 16'd4272, 16'd4292, 16'd4313, 16'd4333, 16'd4354, 16'd4374,
    16'd4395, 16'd4415, 16'd4435, 16'd4455, 16'd4476, 16'd4496, 16'd4516, 16'd4536,
    16'd4556, 16'd4576, 16'd4596, 16'd4615, 16'd4635, 16'd4655, 16'd4675, 16'd4694,
    16'd4714, 16'd4734, 16'd4754, 16'd4773, 16'd4793, 16'd4813, 16'd4832, 16'd4852,
    16'd4872, 16'd4891, 16'd4911, 16'd4931, 16'd4951, 16'd4970, 16'd4990
  };

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] timer_count;
    logic [7:0]  speed;
    logic [1:0]  direction;
    logic [7:0]  amount;
  } item_t;

  // 50 Hz period register plus precomputed +-10% windows for both line rates
  typedef struct packed {
    logic [15:0] period_50hz;
    logic [15:0] lo50;
    logic [16:0] hi50;
    logic [15:0] lo60;
    logic [16:0] hi60;
  } cfg_t;

  typedef struct packed {
    logic        fire_enable;
    logic [15:0] fire_delay;
    logic        full_on;
  } fire_t;

  typedef struct packed {
    logic [7:0] level;
    logic       connected;
    logic [1:0] line_freq;
    logic       report_now;
    logic       store_restart;
  } status_t;

endpackage

// ===== hw/rtl/padf_cfg.sv =====
module padf_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  output padf_pkg::cfg_t      cfg
);
  import padf_pkg::*;

  cfg_t        cfg_r;
  logic [32:0] prod;
  logic [12:0] tenth;
  logic [15:0] lo_new;
  logic [16:0] hi_new;

  // tenth of the written period by reciprocal multiply
  assign prod   = {17'd0, cfg_wdata} * {16'd0, DIV10_MUL};
  assign tenth  = prod[DIV10_SHR +: 13];
  assign lo_new = cfg_wdata - {3'd0, tenth};
  assign hi_new = {1'b0, cfg_wdata} + {4'd0, tenth};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_50hz <= P50_RST;
      cfg_r.lo50        <= LO50_RST;
      cfg_r.hi50        <= HI50_RST;
      cfg_r.lo60        <= LO60_RST;
      cfg_r.hi60        <= HI60_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P50: begin
          cfg_r.period_50hz <= cfg_wdata;
          cfg_r.lo50        <= lo_new;
          cfg_r.hi50        <= hi_new;
        end
        REG_P60: begin
          cfg_r.lo60 <= lo_new;
          cfg_r.hi60 <= hi_new;
        end
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/padf_fire.sv =====
module padf_fire (
  input  logic              is_rise,
  input  logic [7:0]        cur_level,
  input  logic [9:0]        sync_offset,
  input  logic [15:0]       period_50hz,
  output padf_pkg::fire_t   fire
);
  import padf_pkg::*;

  logic [6:0]  tab_idx;
  logic [15:0] tab_val;
  logic [15:0] term;
  logic [15:0] d_raw;
  logic [15:0] d_fix;
  logic        mid;

  // lower half walks the table up from the first entry, upper half mirrors it
  assign tab_idx = (cur_level <= LVL_HALF) ? 7'(cur_level - 8'd1)
                                           : 7'(LVL_MIRROR - cur_level);
  assign tab_val = QUARTER_TAB[tab_idx];
  assign mid     = (cur_level != 8'd0) && (cur_level != LVL_MAX);

  always_comb begin
    priority if (cur_level == 8'd0)      term = 16'd0;
    else if (cur_level <= LVL_HALF)      term = period_50hz - tab_val;
    else if (cur_level != LVL_MAX)       term = tab_val;
    else                                 term = FULL_DELAY;
  end

  assign d_raw = {6'd0, sync_offset} + term;
  assign d_fix = (d_raw > period_50hz) ? d_raw - period_50hz : d_raw;

  assign fire.fire_enable = is_rise && mid;
  assign fire.fire_delay  = (is_rise && mid) ? d_fix : 16'd0;
  assign fire.full_on     = is_rise && (cur_level == LVL_MAX);

endmodule

// ===== hw/rtl/padf_ctrl.sv =====
module padf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  padf_pkg::item_t     item,
  input  padf_pkg::cfg_t      cfg,
  output logic [7:0]          cur_level,
  output logic [9:0]          sync_offset,
  output padf_pkg::status_t   status
);
  import padf_pkg::*;

  typedef enum logic [1:0] {
    DEMO_IDLE = 2'd0,
    DEMO_DOWN = 2'd1,
    DEMO_UP   = 2'd2,
    DEMO_BACK = 2'd3
  } demo_t;

  logic [7:0] cur_r, cur_nxt;
  logic [7:0] tgt_r, tgt_nxt;
  logic [7:0] step_r, step_nxt;
  logic [7:0] div_r, div_nxt;
  logic [7:0] dc_r, dc_nxt;
  demo_t      ph_r, ph_nxt;
  logic [7:0] ret_r, ret_nxt;
  logic [7:0] peak_r, peak_nxt;
  logic [9:0] sync_r, sync_nxt;
  logic       link_r, link_nxt;
  logic [1:0] freq_r, freq_nxt;
  logic       report, store;

  logic [7:0] spd_step, spd_div, spd_low;
  logic       in50, in60;
  logic [7:0] rel_t, fade_end;
  logic [8:0] rel_up;
  logic [8:0] rel_dn;
  logic [14:0] half_tc;

  assign spd_low  = item.speed & SPD_MASK;
  assign spd_step = item.speed[7] ? spd_low + 8'd1 : 8'd1;
  assign spd_div  = item.speed[7] ? 8'd1 : SPD_COARSE - spd_low;

  assign in50 = (item.timer_count > cfg.lo50) && ({1'b0, item.timer_count} < cfg.hi50);
  assign in60 = (item.timer_count > cfg.lo60) && ({1'b0, item.timer_count} < cfg.hi60);

  assign rel_up = {1'b0, cur_r} + {1'b0, item.amount};
  assign rel_dn = {1'b0, cur_r} - {1'b0, item.amount};
  assign half_tc = item.timer_count[15:1];

  always_comb begin
    priority if (item.direction == DIR_UP)  rel_t = rel_up[8] ? LVL_MAX : rel_up[7:0];
    else if (item.direction == DIR_DOWN)    rel_t = rel_dn[8] ? 8'd0 : rel_dn[7:0];
    else                                    rel_t = cur_r;
  end

  always_comb begin
    priority if (item.cmd == CMD_START) fade_end = (item.direction == DIR_UP) ? LVL_MAX : 8'd0;
    else if (item.cmd == CMD_ABS)       fade_end = item.amount;
    else                                fade_end = rel_t;
  end

  always_comb begin
    logic [7:0] sum;
    logic       neg, pos;
    logic       room_dn, room_up;
    logic [7:0] to_max;
    cur_nxt  = cur_r;
    tgt_nxt  = tgt_r;
    step_nxt = step_r;
    div_nxt  = div_r;
    dc_nxt   = dc_r;
    ph_nxt   = ph_r;
    ret_nxt  = ret_r;
    peak_nxt = peak_r;
    sync_nxt = sync_r;
    link_nxt = link_r;
    freq_nxt = freq_r;
    report   = 1'b0;
    store    = 1'b0;
    sum      = 8'd0;
    neg      = 1'b0;
    pos      = 1'b0;
    to_max   = LVL_MAX - cur_r;
    room_dn  = cur_r >= item.amount;
    room_up  = to_max >= item.amount;
    unique case (item.cmd)
      CMD_RISE: begin
        link_nxt = 1'b1;
        priority if (in50) freq_nxt = FREQ_50;
        else if (in60)     freq_nxt = FREQ_60;
        else               freq_nxt = FREQ_UNK;
        // demo advances once the current leg has landed
        if (cur_r == tgt_r) begin
          unique case (ph_r)
            DEMO_DOWN: begin
              ph_nxt   = DEMO_UP;
              tgt_nxt  = peak_r;
              step_nxt = 8'd0 - step_r;
            end
            DEMO_UP: begin
              ph_nxt   = DEMO_BACK;
              tgt_nxt  = ret_r;
              step_nxt = 8'd0 - step_r;
            end
            DEMO_BACK: ph_nxt = DEMO_IDLE;
            default: ;
          endcase
        end
        dc_nxt = dc_r + 8'd1;
        if (dc_nxt == div_r && cur_r != tgt_nxt) begin
          dc_nxt = 8'd0;
          neg    = step_nxt[7];
          pos    = (step_nxt != 8'd0) && !neg;
          sum    = cur_r + step_nxt;
          // clamp on wrap or overshoot
          if ((pos && (sum < cur_r || sum >= tgt_nxt)) ||
              (neg && (sum > cur_r || sum <= tgt_nxt)))
            cur_nxt = tgt_nxt;
          else
            cur_nxt = sum;
          report = (cur_nxt == tgt_nxt);
          store  = 1'b1;
        end
      end
      CMD_FALL: begin
        sync_nxt = (half_tc > {5'd0, SYNC_CAP}) ? SYNC_CAP : half_tc[9:0];
      end
      CMD_DEMO: begin
        dc_nxt   = 8'd0;
        step_nxt = 8'd0;
        if (item.speed != 8'd0) begin
          ret_nxt = cur_r;
          priority if (room_dn && room_up) begin
            tgt_nxt  = cur_r - item.amount;
            peak_nxt = cur_r + item.amount;
          end else if (room_dn) begin
            tgt_nxt  = cur_r - item.amount - item.amount + to_max;
            peak_nxt = LVL_MAX;
          end else if (room_up) begin
            tgt_nxt  = 8'd0;
            peak_nxt = item.amount + item.amount;
          end
          ph_nxt   = DEMO_DOWN;
          div_nxt  = spd_div;
          step_nxt = (tgt_nxt <= cur_r) ? 8'd0 - spd_step : spd_step;
        end
      end
      CMD_START, CMD_ABS, CMD_REL: begin
        ph_nxt   = DEMO_IDLE;
        dc_nxt   = 8'd0;
        step_nxt = 8'd0;
        if (item.speed == 8'd0) begin
          cur_nxt = fade_end;
          report  = 1'b1;
        end else begin
          tgt_nxt = fade_end;
          if (fade_end != cur_r) begin
            div_nxt  = spd_div;
            step_nxt = (fade_end < cur_r) ? 8'd0 - spd_step : spd_step;
          end
        end
      end
      CMD_STOP: begin
        ph_nxt   = DEMO_IDLE;
        step_nxt = 8'd0;
        report   = 1'b1;
      end
      CMD_SET: begin
        cur_nxt = item.amount;
        tgt_nxt = item.amount;
      end
      CMD_LOST: link_nxt = 1'b0;
      CMD_TICK: report = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= 8'd0;
      tgt_r  <= 8'd0;
      step_r <= 8'd0;
      div_r  <= 8'd0;
      dc_r   <= 8'd0;
      ph_r   <= DEMO_IDLE;
      ret_r  <= 8'd0;
      peak_r <= 8'd0;
      sync_r <= 10'd0;
      link_r <= 1'b0;
      freq_r <= FREQ_UNK;
    end else if (en) begin
      cur_r  <= cur_nxt;
      tgt_r  <= tgt_nxt;
      step_r <= step_nxt;
      div_r  <= div_nxt;
      dc_r   <= dc_nxt;
      ph_r   <= ph_nxt;
      ret_r  <= ret_nxt;
      peak_r <= peak_nxt;
      sync_r <= sync_nxt;
      link_r <= link_nxt;
      freq_r <= freq_nxt;
    end
  end

  assign cur_level            = cur_r;
  assign sync_offset          = sync_r;
  assign status.level         = cur_nxt;
  assign status.connected     = link_nxt;
  assign status.line_freq     = freq_nxt;
  assign status.report_now    = report;
  assign status.store_restart = store;

endmodule

// ===== hw/rtl/phase_angle_dimmer_with_fade.sv =====
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+-------------------------------------------
// in_     | in  | in_tvalid/tready   | tuser: cmd; tdata: timer, speed, dir, amount
// out_    | out | out_tvalid/tready  | tdata: fire, delay, full, level, status
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata (period registers)
//
// One request per clock sustained while out_tready stays high; a request lands in
// the input register, is decoded in one pass and its result is written to the
// output register, raising out_tvalid, when that register is free or draining.
// rst_n is synchronous, active low; it restores periods, clears all but the payload.
// When out_tready is low with a result waiting, the output register holds and the
// input register still takes one more request before in_tready drops.
module phase_angle_dimmer_with_fade (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [3:0]  in_tuser,   // cmd
  input  logic [39:0] in_tdata,   // timer_count, speed, direction, amount, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // fire_enable, fire_delay, full_on, level,
                                  // connected, line_freq, report_now,
                                  // store_restart, zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import padf_pkg::*;

  item_t       s1_item_r;
  logic        s1_valid_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        advance;

  cfg_t        cfg;
  logic [7:0]  cur_level;
  logic [9:0]  sync_offset;
  fire_t       fire;
  status_t     status;

  // a request moves to the output stage when that stage is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.cmd         <= in_tuser;
      s1_item_r.timer_count <= in_tdata[15:0];
      s1_item_r.speed       <= in_tdata[23:16];
      s1_item_r.direction   <= in_tdata[25:24];
      s1_item_r.amount      <= in_tdata[33:26];
    end
  end

  padf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  padf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .item        (s1_item_r),
    .cfg         (cfg),
    .cur_level   (cur_level),
    .sync_offset (sync_offset),
    .status      (status)
  );

  // firing uses the level as it stood before this edge's fade step
  padf_fire u_fire (
    .is_rise     (s1_item_r.cmd == CMD_RISE),
    .cur_level   (cur_level),
    .sync_offset (sync_offset),
    .period_50hz (cfg.period_50hz),
    .fire        (fire)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {1'b0, status.store_restart, status.report_now, status.line_freq,
                     status.connected, status.level, fire.full_on, fire.fire_delay,
                     fire.fire_enable};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/padf_checker.sv =====
module padf_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [3:0]  in_tuser,   // cmd
  input  logic [39:0] in_tdata,   // timer_count, speed, direction, amount, zero pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // fire_enable, fire_delay, full_on, level,
                                  // connected, line_freq, report_now,
                                  // store_restart, zero pad
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_cnt,
  output int          awaited,
  output int          checked,
  output int          pulses,
  output int          steps
);
  import padf_pkg::*;

  localparam logic [1:0] DEMO_OFF  = 2'd0;
  localparam logic [1:0] DEMO_FALL = 2'd1;
  localparam logic [1:0] DEMO_RISE = 2'd2;
  localparam logic [1:0] DEMO_BACK = 2'd3;

  localparam logic [15:0] GATE_HOLD_DELAY = 16'd100;
  localparam logic [14:0] OFFSET_LIMIT    = 15'd600;

  // power-linear firing curve, 845 .. 4990, the first half of the reset 50 Hz period
  localparam logic [15:0] FIRE_CURVE [0:126] = '{
    16'd845,  16'd1068, 16'd1225, 16'd1352, 16'd1459, 16'd1553, 16'd1638, 16'd1716,
    16'd1788, 16'd1855, 16'd1917, 16'd1976, 16'd2032, 16'd2086, 16'd2138, 16'd2188,
    16'd2236, 16'd2282, 16'd2327, 16'd2370, 16'd2412, 16'd2453, 16'd2493, 16'd2532,
    16'd2570, 16'd2607, 16'd2643, 16'd2679, 16'd2714, 16'd2748, 16'd2782, 16'd2815,
    16'd2848, 16'd2880, 16'd2911, 16'd2942, 16'd2972, 16'd3002, 16'd3032, 16'd3061,
    16'd3090, 16'd3119, 16'd3147, 16'd3175, 16'd3203, 16'd3230, 16'd3257, 16'd3284,
    16'd3311, 16'd3337, 16'd3363, 16'd3389, 16'd3415, 16'd3440, 16'd3465, 16'd3490,
    16'd3515, 16'd3539, 16'd3563, 16'd3587, 16'd3611, 16'd3635, 16'd3659, 16'd3682,
    16'd3705, 16'd3728, 16'd3751, 16'd3774, 16'd3797, 16'd3820, 16'd3843, 16'd3865,
    16'd3887, 16'd3909, 16'd3931, 16'd3953, 16'd3975, 16'd3997, 16'd4019, 16'd4041,
    16'd4062, 16'd4083, 16'd4104, 16'd4125, 16'd4146, 16'd4167, 16'd4188, 16'd4209,
    16'd4230, 16'd4251, 16'd4272, 16'd4292, 16'd4313, 16'd4333, 16'd4354, 16'd4374,
    16'd4395, 16'd4415, 16'd4435, 16'd4455, 16'd4476, 16'd4496, 16'd4516, 16'd4536,
    16'd4556, 16'd4576, 16'd4596, 16'd4615, 16'd4635, 16'd4655, 16'd4675, 16'd4694,
    16'd4714, 16'd4734, 16'd4754, 16'd4773, 16'd4793, 16'd4813, 16'd4832, 16'd4852,
    16'd4872, 16'd4891, 16'd4911, 16'd4931, 16'd4951, 16'd4970, 16'd4990
  };

  typedef struct packed {
    logic        fire;
    logic [15:0] delay;
    logic        full;
    logic [7:0]  level;
    logic        link;
    logic [1:0]  freq;
    logic        report;
    logic        store;
  } dim_out_t;

  // shadow of the dimmer
  logic [15:0] per50, per60;
  logic [7:0]  lvl, goal, step, div_len, div_cnt, demo_home, demo_top;
  logic [1:0]  demo_st;
  logic [9:0]  sync_ofs;
  logic        link;
  logic [1:0]  freq;

  dim_out_t owed_results [$];
  dim_out_t want, got;

  function automatic bit in_band(int unsigned t, int unsigned p);
    return t > p - p / 10 && t < p + p / 10;
  endfunction

  task automatic set_rate(input logic [7:0] spd);
    if (spd[7]) begin
      step    = {1'b0, spd[6:0]} + 8'd1;
      div_len = 8'd1;
    end else begin
      step    = 8'd1;
      div_len = 8'h80 - {1'b0, spd[6:0]};
    end
  endtask

  task automatic fade_to(input logic [7:0] spd, input logic [7:0] endl, output logic rep);
    demo_st = DEMO_OFF;
    div_cnt = 8'd0;
    step    = 8'd0;
    rep     = 1'b0;
    if (spd == 8'd0) begin
      lvl = endl;
      rep = 1'b1;
    end else begin
      goal = endl;
      if (goal != lvl) begin
        set_rate(spd);
        if (goal < lvl) step = 8'd0 - step;
      end
    end
  endtask

  task automatic dimmer_step(input logic [3:0] cmd, input logic [39:0] data,
                             output dim_out_t r);
    logic [15:0] tc, d;
    logic [7:0]  spd, amt, old, to_min, to_max, t;
    logic [1:0]  dir;
    logic        neg, pos;
    tc  = data[15:0];
    spd = data[23:16];
    dir = data[25:24];
    amt = data[33:26];
    r   = '0;
    case (cmd)
      CMD_RISE: begin
        link = 1'b1;
        if (in_band(tc, per50))      freq = FREQ_50;
        else if (in_band(tc, per60)) freq = FREQ_60;
        else                         freq = FREQ_UNK;
        // demo advances only once the current leg has landed
        if (lvl == goal) begin
          case (demo_st)
            DEMO_FALL: begin
              demo_st = DEMO_RISE;
              goal    = demo_top;
              step    = 8'd0 - step;
            end
            DEMO_RISE: begin
              demo_st = DEMO_BACK;
              goal    = demo_home;
              step    = 8'd0 - step;
            end
            DEMO_BACK: demo_st = DEMO_OFF;
            default: ;
          endcase
        end
        d = 16'(sync_ofs);
        if (lvl > 8'd0 && lvl <= 8'd127)
          d = d + (per50 - FIRE_CURVE[lvl - 8'd1]);
        else if (lvl > 8'd127 && lvl < 8'd255)
          d = d + FIRE_CURVE[8'd254 - lvl];
        else if (lvl == 8'd255)
          d = d + GATE_HOLD_DELAY;
        if (d > per50) d = d - per50;
        if (lvl > 8'd0 && lvl != 8'd255) begin
          r.fire  = 1'b1;
          r.delay = d;
        end
        r.full = (lvl == 8'd255);
        div_cnt = div_cnt + 8'd1;
        if (div_cnt == div_len && lvl != goal) begin
          old     = lvl;
          neg     = step[7];
          pos     = step != 8'd0 && !neg;
          div_cnt = 8'd0;
          lvl     = lvl + step;
          // overshoot or wrap lands on the target
          if ((pos && (lvl < old || lvl >= goal)) || (neg && (lvl > old || lvl <= goal)))
            lvl = goal;
          r.report = (lvl == goal);
          r.store  = 1'b1;
        end
      end
      CMD_FALL: sync_ofs = ((tc >> 1) > 16'(OFFSET_LIMIT)) ? 10'(OFFSET_LIMIT) : tc[10:1];
      CMD_DEMO: begin
        div_cnt = 8'd0;
        step    = 8'd0;
        if (spd != 8'd0) begin
          to_min    = lvl;
          to_max    = 8'd255 - lvl;
          demo_home = lvl;
          if (to_min >= amt && to_max >= amt) begin
            goal     = lvl - amt;
            demo_top = lvl + amt;
          end else if (to_min >= amt) begin
            goal     = lvl - amt - amt + to_max;
            demo_top = 8'd255;
          end else if (to_max >= amt) begin
            goal     = 8'd0;
            demo_top = lvl + amt + amt - to_min;
          end
          demo_st = DEMO_FALL;
          set_rate(spd);
          if (goal <= lvl) step = 8'd0 - step;
        end
      end
      CMD_START: fade_to(spd, (dir == DIR_UP) ? 8'd255 : 8'd0, r.report);
      CMD_STOP: begin
        demo_st  = DEMO_OFF;
        step     = 8'd0;
        r.report = 1'b1;
      end
      CMD_ABS: fade_to(spd, amt, r.report);
      CMD_REL: begin
        t = lvl;
        if (dir == DIR_UP) begin
          t = lvl + amt;
          if (t < lvl) t = 8'd255;
        end else if (dir == DIR_DOWN) begin
          t = lvl - amt;
          if (t > lvl) t = 8'd0;
        end
        fade_to(spd, t, r.report);
      end
      CMD_SET: begin
        lvl  = amt;
        goal = amt;
      end
      CMD_LOST: link = 1'b0;
      CMD_TICK: r.report = 1'b1;
      default: ;
    endcase
    r.level = lvl;
    r.link  = link;
    r.freq  = freq;
  endtask

  task automatic cmp_field(input string name, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      per50 = P50_RST;
      per60 = P60_RST;
      {lvl, goal, step, div_len, div_cnt, demo_home, demo_top} = '0;
      demo_st  = DEMO_OFF;
      sync_ofs = '0;
      link     = 1'b0;
      freq     = FREQ_UNK;
      owed_results.delete();
      awaited = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[16:1], out_tdata[17], out_tdata[25:18],
               out_tdata[26], out_tdata[28:27], out_tdata[29], out_tdata[30]};
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_cnt++;
        end else begin
          want = owed_results.pop_front();
          cmp_field("fire_enable", want.fire, got.fire);
          cmp_field("fire_delay", want.delay, got.delay);
          cmp_field("full_on", want.full, got.full);
          cmp_field("level", want.level, got.level);
          cmp_field("connected", want.link, got.link);
          cmp_field("line_freq", want.freq, got.freq);
          cmp_field("report_now", want.report, got.report);
          cmp_field("store_restart", want.store, got.store);
          checked++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_P50) per50 = cfg_wdata;
        else                      per60 = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        dimmer_step(in_tuser, in_tdata, want);
        owed_results.push_back(want);
        if (want.fire)  pulses++;
        if (want.store) steps++;
      end
      awaited = owed_results.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import padf_pkg::*;

  // commands the block has no use for; they must pass through untouched
  localparam logic [3:0] CMD_SPARE_FIRST = 4'd10;
  localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;
  // direction codes beyond the two the package names
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_ODD  = 2'd3;

  // receiver stall patterns
  localparam int RX_OPEN   = 0;  // always ready
  localparam int RX_COIN   = 1;  // ready half the time
  localparam int RX_STINGY = 2;  // ready one cycle in eight
  localparam int RX_MOSTLY = 3;  // ready three quarters of the time

  localparam int HOLD_LEN        = 60;   // long receiver hold-off, in cycles
  localparam int RAND_PER_PHASE  = 245;
  localparam int DRAIN_SLACK     = 4;    // settling margin after the last result is back

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [3:0]  in_tuser;   // cmd
  logic [39:0] in_tdata;   // timer_count, speed, direction, amount, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // fire_enable, fire_delay, full_on, level, connected,
                           // line_freq, report_now, store_restart, zero pad
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int fail_cnt, awaited, checked, pulses, steps;

  // sender state: requests left in the current burst
  int burst_left;
  int sent;
  int n_settings;
  // our own copy of the period registers, used to aim edge timings at the windows
  logic [15:0] p50_now, p60_now;
  // set by the stimulus, cleared by the receiver once its hold-off is over
  bit hold_off;

  phase_angle_dimmer_with_fade dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  padf_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_cnt   (fail_cnt),
    .awaited    (awaited),
    .checked    (checked),
    .pulses     (pulses),
    .steps      (steps)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop. Slowest sane run is about 1500 requests plus one long hold-off
  // per phase; this limit leaves ample room for that.
  initial begin
    #3200000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: picks a stall pattern for a random stretch, then another.
  // A hold-off request from the stimulus side overrides the pattern.
  initial begin
    int rx_mode, rx_left;
    out_tready = 1'b0;
    rx_mode    = RX_OPEN;
    rx_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(RX_OPEN, RX_MOSTLY);
          rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= $urandom_range(0, 1);
          RX_STINGY: out_tready <= ($urandom_range(0, 7) == 0);
          default:   out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // One request. Valid stays up across a burst; at the end of a burst the
  // sender backs off a random number of cycles so gaps land on every phase.
  task automatic send_req(input logic [3:0] cmd, input logic [15:0] tc,
                          input logic [7:0] spd, input logic [1:0] dir,
                          input logic [7:0] amt);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, amt, dir, spd, tc};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 10);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Quiet the input and wait until every result is back, plus a settling margin.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_periods(input logic [15:0] p50, input logic [15:0] p60);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_P50;
    cfg_wdata <= p50;
    @(negedge clk);
    cfg_index <= REG_P60;
    cfg_wdata <= p60;
    @(negedge clk);
    cfg_we    <= 1'b0;
    p50_now = p50;
    p60_now = p60;
    n_settings++;
  endtask

  // Rising-edge timing: mostly near one of the periods, often right on a
  // window boundary, sometimes anywhere.
  function automatic logic [15:0] edge_time();
    int unsigned p, j;
    p = $urandom_range(0, 1) ? p50_now : p60_now;
    case ($urandom_range(0, 4))
      0: return 16'(p - p / 10 + $urandom_range(0, 2) - 1);
      1: return 16'(p + p / 10 + $urandom_range(0, 2) - 1);
      2: begin
        j = $urandom_range(0, p / 4);
        return 16'(p - p / 8 + j);
      end
      3: return 16'(p);
      default: return 16'($urandom);
    endcase
  endfunction

  // Fade speed: weighted toward rates that actually finish a fade in a
  // reasonable number of edges.
  function automatic logic [7:0] pick_speed();
    case ($urandom_range(0, 9))
      0, 1:       return 8'd0;
      2, 3, 4, 5: return {1'b1, 7'($urandom)};
      6, 7, 8:    return 8'h70 + 8'($urandom_range(0, 15));
      default:    return 8'($urandom_range(1, 127));
    endcase
  endfunction

  function automatic logic [7:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 1) ? 1 : 254);
      default: return 8'($urandom);
    endcase
  endfunction

  // Mains-like traffic: a stream of zero-cross edges with commands mixed in,
  // plus a little junk. One forced long receiver hold-off per phase.
  task automatic mains_traffic(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        hold_off   = 1'b1;
        burst_left = 40;
      end
      r = $urandom_range(0, 99);
      if (r < 50)
        send_req(CMD_RISE, edge_time(), 8'($urandom), 2'($urandom), 8'($urandom));
      else if (r < 62)
        send_req(CMD_FALL,
                 ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 1300)) : 16'($urandom),
                 8'($urandom), 2'($urandom), 8'($urandom));
      else if (r < 96)
        send_req(4'($urandom_range(CMD_DEMO, CMD_TICK)), 16'($urandom), pick_speed(),
                 2'($urandom_range(DIR_NONE, DIR_ODD)), pick_amount());
      else
        send_req(4'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), 16'($urandom),
                 8'($urandom), 2'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = '0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_P50;
    cfg_wdata  = '0;
    hold_off   = 1'b0;
    burst_left = 0;
    sent       = 0;
    n_settings = 1;
    p50_now    = P50_RST;
    p60_now    = P60_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed, reset periods (10000 / 8333) ---
    send_req(CMD_TICK, 16'd0, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_RISE, 16'd10000, 8'd0, DIR_NONE, 8'd0);     // level 0: no pulse
    send_req(CMD_FALL, 16'hffff, 8'hff, DIR_ODD, 8'hff);     // offset capped
    send_req(CMD_SET, 16'd0, 8'd0, DIR_NONE, 8'd255);
    send_req(CMD_RISE, 16'd8333, 8'd0, DIR_NONE, 8'd0);      // full on, 60 Hz
    send_req(CMD_SET, 16'd0, 8'd0, DIR_NONE, 8'd1);
    send_req(CMD_RISE, 16'd9000, 8'd0, DIR_NONE, 8'd0);      // low 50 Hz bound is open
    send_req(CMD_FALL, 16'd1, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_SET, 16'd0, 8'd0, DIR_NONE, 8'd127);
    send_req(CMD_RISE, 16'd11000, 8'd0, DIR_NONE, 8'd0);     // high bound: unknown
    send_req(CMD_SET, 16'd0, 8'd0, DIR_NONE, 8'd128);        // mirrored half of curve
    send_req(CMD_RISE, 16'd10999, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_SET, 16'd0, 8'd0, DIR_NONE, 8'd254);
    send_req(CMD_RISE, 16'd0, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_ABS, 16'd0, 8'd0, DIR_NONE, 8'd200);        // immediate
    // step of -128: one plain step, then the wrapping step clamps on the target
    send_req(CMD_ABS, 16'd0, 8'hff, DIR_NONE, 8'd10);
    send_req(CMD_RISE, 16'd10000, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_RISE, 16'd10000, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_REL, 16'd0, 8'd0, DIR_UP, 8'd255);          // saturates high
    send_req(CMD_REL, 16'd0, 8'd0, DIR_DOWN, 8'd255);        // saturates low
    send_req(CMD_REL, 16'd0, 8'h81, DIR_ODD, 8'd7);          // odd direction = none
    send_req(CMD_START, 16'd0, 8'h85, DIR_UP, 8'd0);
    send_req(CMD_RISE, 16'd8333, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_STOP, 16'd0, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_SET, 16'd0, 8'd0, DIR_NONE, 8'd100);
    send_req(CMD_DEMO, 16'd0, 8'h90, DIR_NONE, 8'd200);      // no room either way
    send_req(CMD_RISE, 16'd10000, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_LOST, 16'd0, 8'd0, DIR_NONE, 8'd0);
    send_req(CMD_SPARE_LAST, 16'hffff, 8'hff, DIR_ODD, 8'hff);

    mains_traffic(RAND_PER_PHASE);

    // --- further period settings, extremes among them ---
    for (int k = 0; k < 5; k++) begin
      drain();
      case (k)
        0:       write_periods(16'd20000, 16'd16667);
        1:       write_periods(16'd0, 16'd0);
        2:       write_periods(16'hffff, 16'hffff);
        3:       write_periods(16'hffff, 16'd0);
        default: write_periods(16'($urandom_range(500, 30000)), 16'($urandom));
      endcase
      mains_traffic(RAND_PER_PHASE);
    end

    drain();
    $display("run: %0d requests over %0d period settings, %0d results compared",
             sent, n_settings, checked);
    $display("run: %0d gate pulses scheduled, %0d fade steps taken", pulses, steps);
    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
